### sv/vmsd_pkg.sv
// ----------------------------------------------------------------------------
// vmsd_pkg
// Shared types and constants for the vector mean and standard deviation block.
// ----------------------------------------------------------------------------
`default_nettype none

package vmsd_pkg;

  // Field and accumulator widths
  localparam int unsigned DATA_W  = 32;  // sample, ref_mean, mean_value
  localparam int unsigned STD_W   = 31;  // std_deviation
  localparam int unsigned LEN_W   = 9;   // vector_length and sample count
  localparam int unsigned SUM_W   = 40;  // running sample sum
  localparam int unsigned DIFF_W  = 34;  // sample minus reference mean
  localparam int unsigned MAG_W   = 33;  // magnitude of the deviation
  localparam int unsigned SQ_W    = 64;  // squared deviation, Q32.32
  localparam int unsigned ROOT_W  = 32;  // full square root of a 64-bit value

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ABS,
    S_MUL,
    S_ACC,
    S_DIV,
    S_SQRT,
    S_LOAD
  } vmsd_state_e;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;
    logic accept;
    logic abs_en;
    logic mul_en;
    logic acc_en;
    logic div_start;
    logic sqrt_start;
    logic load;
  } vmsd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;
    logic close;
    logic div_busy;
    logic sqrt_busy;
    logic out_free;
  } vmsd_status_t;

endpackage

`default_nettype wire

### sv/vmsd_div.sv
// ----------------------------------------------------------------------------
// vmsd_div
// Restoring divider, one quotient bit per cycle, by the vector length.
// ----------------------------------------------------------------------------
`default_nettype none

module vmsd_div #(
  parameter int unsigned WIDTH = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [WIDTH-1:0]             dividend_i,
  input  wire logic [vmsd_pkg::LEN_W-1:0]   divisor_i,
  output logic                              busy_o,
  output logic [WIDTH-1:0]                  quotient_o
);

  localparam int unsigned CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic                          busy_q, busy_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [WIDTH-1:0]              quo_q, quo_d;
  logic [vmsd_pkg::LEN_W-1:0]    rem_q, rem_d;
  logic [vmsd_pkg::LEN_W:0]      rem_sh;
  logic                          ge;

  // Shift in one dividend bit, subtract the divisor when it fits
  always_comb begin
    rem_sh = {rem_q, quo_q[WIDTH-1]};
    ge     = rem_sh >= {1'b0, divisor_i};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(WIDTH - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d = {quo_q[WIDTH-2:0], ge};
      rem_d = vmsd_pkg::LEN_W'(ge ? (rem_sh - {1'b0, divisor_i}) : rem_sh);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

### sv/vmsd_sqrt.sv
// ----------------------------------------------------------------------------
// vmsd_sqrt
// Digit-by-digit integer square root of a 64-bit value, one root bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vmsd_sqrt (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [vmsd_pkg::SQ_W-1:0]     radicand_i,
  output logic                               busy_o,
  output logic [vmsd_pkg::ROOT_W-1:0]        root_o
);

  localparam int unsigned CNT_W = $clog2(vmsd_pkg::ROOT_W);
  localparam int unsigned REM_W = vmsd_pkg::ROOT_W + 2;

  logic                          busy_q, busy_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic [vmsd_pkg::SQ_W-1:0]     rad_q, rad_d;
  logic [REM_W-1:0]              rem_q, rem_d;
  logic [vmsd_pkg::ROOT_W-1:0]   root_q, root_d;
  logic [REM_W+1:0]              rem_sh;
  logic [REM_W+1:0]              trial;
  logic                          ge;

  // Bring down two radicand bits, try (4*root + 1)
  always_comb begin
    rem_sh = {rem_q, rad_q[vmsd_pkg::SQ_W-1 -: 2]};
    trial  = (REM_W + 2)'({root_q, 2'b01});
    ge     = rem_sh >= trial;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(vmsd_pkg::ROOT_W - 1);
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rad_d  = {rad_q[vmsd_pkg::SQ_W-3:0], 2'b00};
      rem_d  = REM_W'(ge ? (rem_sh - trial) : rem_sh);
      root_d = {root_q[vmsd_pkg::ROOT_W-2:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

### sv/vmsd_dp.sv
// ----------------------------------------------------------------------------
// vmsd_dp
// Datapath: length register, accumulators, square unit, divide and square
// root units, and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module vmsd_dp #(
  parameter int unsigned MAX_LENGTH   = 256,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire vmsd_pkg::vmsd_cmd_t           cmd_i,
  output vmsd_pkg::vmsd_status_t             status_o,
  input  wire logic                          in_valid_i,
  input  wire logic                          cfg_wr_en_i,
  input  wire logic [vmsd_pkg::LEN_W-1:0]    cfg_wr_data_i,
  input  wire logic [vmsd_pkg::DATA_W-1:0]   sample_i,
  input  wire logic [vmsd_pkg::DATA_W-1:0]   ref_mean_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [vmsd_pkg::DATA_W-1:0]        mean_value_o,
  output logic [vmsd_pkg::STD_W-1:0]         std_deviation_o
);

  localparam int unsigned LEN_W  = vmsd_pkg::LEN_W;
  localparam int unsigned SUM_W  = vmsd_pkg::SUM_W;
  localparam int unsigned SQ_W   = vmsd_pkg::SQ_W;
  localparam int unsigned DIFF_W = vmsd_pkg::DIFF_W;
  localparam int unsigned MAG_W  = vmsd_pkg::MAG_W;
  localparam int unsigned DATA_W = vmsd_pkg::DATA_W;
  localparam int unsigned STD_W  = vmsd_pkg::STD_W;
  localparam int unsigned ROOT_W = vmsd_pkg::ROOT_W;

  // Effective length register: zero acts as one, clamp to MAX_LENGTH
  logic [LEN_W-1:0] len_q, len_d;

  always_comb begin
    if (cfg_wr_data_i == '0) begin
      len_d = LEN_W'(1);
    end else if (32'(cfg_wr_data_i) > MAX_LENGTH) begin
      len_d = LEN_W'(MAX_LENGTH);
    end else begin
      len_d = cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_W'(1);
    end else if (cfg_wr_en_i) begin
      len_q <= len_d;
    end
  end

  // Sign-extend the used low bits of each field
  logic signed [SAMPLE_WIDTH-1:0] s_low, r_low;
  logic signed [DIFF_W-1:0]       s_ext, r_ext;

  assign s_low = sample_i[SAMPLE_WIDTH-1:0];
  assign r_low = ref_mean_i[SAMPLE_WIDTH-1:0];
  assign s_ext = DIFF_W'(s_low);
  assign r_ext = DIFF_W'(r_low);

  // Deviation pipeline: difference, magnitude, square
  logic signed [DIFF_W-1:0] diff_q;
  logic [MAG_W-1:0]         mag_q;
  logic [SQ_W-1:0]          sq_q;
  logic [SQ_W-1:0]          prod;

  assign prod = mag_q[MAG_W-2:0] * mag_q[MAG_W-2:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      diff_q <= s_ext - r_ext;
    end
    if (cmd_i.abs_en) begin
      mag_q <= diff_q[DIFF_W-1] ? MAG_W'(-diff_q) : MAG_W'(diff_q);
    end
    // saturate a magnitude beyond 32 bits
    if (cmd_i.mul_en) begin
      sq_q <= mag_q[MAG_W-1] ? '1 : prod;
    end
  end

  // Accumulators
  logic signed [SUM_W-1:0] sum_q;
  logic [SQ_W-1:0]         sqs_q, sqs_d;
  logic [LEN_W-1:0]        cnt_q;
  logic [SQ_W:0]           sqs_add;

  assign sqs_add = {1'b0, sqs_q} + {1'b0, sq_q};
  assign sqs_d   = sqs_add[SQ_W] ? '1 : sqs_add[SQ_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      sqs_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.accept) begin
      sum_q <= sum_q + SUM_W'(s_ext);
      cnt_q <= cnt_q + 1'b1;
    end else if (cmd_i.div_start) begin
      // vector closes: hand off to the dividers and clear
      sum_q <= '0;
      sqs_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.acc_en) begin
      sqs_q <= sqs_d;
    end
  end

  // Divide sum and square sum by the length
  logic [SUM_W-1:0] sum_mag;
  logic [SUM_W-1:0] mean_quo;
  logic [SQ_W-1:0]  msd_quo;
  logic             mean_busy, msd_busy;
  logic             neg_q;

  assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      neg_q <= sum_q[SUM_W-1];
    end
  end

  vmsd_div #(
    .WIDTH (SUM_W)
  ) u_mean_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_mag),
    .divisor_i  (len_q),
    .busy_o     (mean_busy),
    .quotient_o (mean_quo)
  );

  vmsd_div #(
    .WIDTH (SQ_W)
  ) u_msd_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sqs_d),
    .divisor_i  (len_q),
    .busy_o     (msd_busy),
    .quotient_o (msd_quo)
  );

  // Square root of the mean squared deviation
  logic [ROOT_W-1:0] root;
  logic              sqrt_busy;

  vmsd_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt_start),
    .radicand_i (msd_quo),
    .busy_o     (sqrt_busy),
    .root_o     (root)
  );

  // Output word register
  logic              out_valid_q;
  logic [DATA_W-1:0] mean_q;
  logic [STD_W-1:0]  std_q;
  logic [DATA_W-1:0] mean_lo;

  assign mean_lo = mean_quo[DATA_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mean_q <= neg_q ? (-mean_lo) : mean_lo;
      std_q  <= root[ROOT_W-1] ? '1 : root[STD_W-1:0];
    end
  end

  // Status back to the controller
  assign status_o.in_valid  = in_valid_i;
  assign status_o.close     = cnt_q >= len_q;
  assign status_o.div_busy  = mean_busy | msd_busy;
  assign status_o.sqrt_busy = sqrt_busy;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign mean_value_o    = mean_q;
  assign std_deviation_o = std_q;

endmodule

`default_nettype wire

### sv/vmsd_ctrl.sv
// ----------------------------------------------------------------------------
// vmsd_ctrl
// Controller: steps each sample through the datapath and sequences the
// divide, square root and output load at the end of a vector.
// ----------------------------------------------------------------------------
`default_nettype none

module vmsd_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire vmsd_pkg::vmsd_status_t  status_i,
  output vmsd_pkg::vmsd_cmd_t          cmd_o
);

  vmsd_pkg::vmsd_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      vmsd_pkg::S_IDLE: begin
        if (status_i.in_valid) state_d = vmsd_pkg::S_ABS;
      end
      vmsd_pkg::S_ABS: state_d = vmsd_pkg::S_MUL;
      vmsd_pkg::S_MUL: state_d = vmsd_pkg::S_ACC;
      vmsd_pkg::S_ACC: begin
        state_d = status_i.close ? vmsd_pkg::S_DIV : vmsd_pkg::S_IDLE;
      end
      vmsd_pkg::S_DIV: begin
        if (!status_i.div_busy) state_d = vmsd_pkg::S_SQRT;
      end
      vmsd_pkg::S_SQRT: begin
        if (!status_i.sqrt_busy) state_d = vmsd_pkg::S_LOAD;
      end
      vmsd_pkg::S_LOAD: begin
        if (status_i.out_free) state_d = vmsd_pkg::S_IDLE;
      end
      default: state_d = vmsd_pkg::S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      vmsd_pkg::S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.accept   = status_i.in_valid;
      end
      vmsd_pkg::S_ABS: cmd_o.abs_en = 1'b1;
      vmsd_pkg::S_MUL: cmd_o.mul_en = 1'b1;
      vmsd_pkg::S_ACC: begin
        cmd_o.acc_en    = 1'b1;
        cmd_o.div_start = status_i.close;
      end
      vmsd_pkg::S_DIV: cmd_o.sqrt_start = !status_i.div_busy;
      vmsd_pkg::S_SQRT: ;
      vmsd_pkg::S_LOAD: cmd_o.load = status_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vmsd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### sv/vector_mean_and_std_deviation.sv
// ----------------------------------------------------------------------------
// vector_mean_and_std_deviation
// Mean and population standard deviation, about ref_mean, of a Q16.16 vector.
//
//   Channel  Dir  Handshake                  Content
//   s_axis   in   s_axis_tvalid/tready       sample, ref_mean
//   m_axis   out  m_axis_tvalid/tready       mean_value, std_deviation
//   cfg      in   cfg_wr_en_i                vector_length
//
// Each sample steps through the controller states for accept, magnitude,
// square and accumulate; one sample is in flight at a time.
// The closing sample of a vector then passes through division (64
// bit-serial steps, then the hand-off to the root), the bit-serial square
// root (32 steps, then the hand-off to the load) and the result load.
// The result waits in an output register; a new vector may stream in
// meanwhile, and only the next result load (and the input behind it) waits
// for m_axis_tready.
// Reset clears the accumulators and sets the length to one; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_mean_and_std_deviation #(
  parameter int unsigned MAX_LENGTH   = 256,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_wr_en_i,
  input  wire logic [8:0]  cfg_wr_data_i,   // vector_length
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,    // [31:0] sample, [63:32] ref_mean
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata     // [31:0] mean_value,
                                            // [62:32] std_deviation, [63] zero
);

  vmsd_pkg::vmsd_cmd_t    cmd;
  vmsd_pkg::vmsd_status_t status;

  logic [vmsd_pkg::DATA_W-1:0] mean_value;
  logic [vmsd_pkg::STD_W-1:0]  std_deviation;

  vmsd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  vmsd_dp #(
    .MAX_LENGTH   (MAX_LENGTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .in_valid_i      (s_axis_tvalid),
    .cfg_wr_en_i     (cfg_wr_en_i),
    .cfg_wr_data_i   (cfg_wr_data_i),
    .sample_i        (s_axis_tdata[31:0]),
    .ref_mean_i      (s_axis_tdata[63:32]),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .mean_value_o    (mean_value),
    .std_deviation_o (std_deviation)
  );

  assign s_axis_tready = cmd.in_ready;
  assign m_axis_tdata  = {1'b0, std_deviation, mean_value};

  // Load a result only into a free output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> status.out_free)
    else $error("result loaded over a pending output word");

  // Start the square root only once both divisions are done
  a_sqrt_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.sqrt_start |-> !status.div_busy)
    else $error("square root started during division");

  // Dividers run after a vector closes
  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> status.div_busy)
    else $error("division did not start on vector close");

  // One sample in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept |=> !s_axis_tready)
    else $error("input taken while a sample is in flight");

  // A loaded result shows on the output next cycle
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> m_axis_tvalid)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

### tb/vmsd_checker.sv
// ----------------------------------------------------------------------------
// vmsd_checker
// Watches the configuration, input and result channels of the vector mean
// and standard deviation block. It keeps its own copy of the accumulators and
// the length register. For every closing sample it queues the expected mean
// and deviation, and it compares each result word with the oldest entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module vmsd_checker
  import vmsd_pkg::*;
#(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_wr_en_i,
  input  logic [LEN_W-1:0]  cfg_wr_data_i,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,    // [31:0] sample, [63:32] ref_mean
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [63:0]       m_axis_tdata,    // [31:0] mean_value,
                                             // [62:32] std_deviation, [63] zero
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic [DATA_W-1:0] mean;
    logic [STD_W-1:0]  std_dev;
  } moments_t;

  moments_t          moments_q[$];
  logic [LEN_W-1:0]  length_reg;
  longint            sum_acc;
  logic [SQ_W-1:0]   sq_acc;
  int unsigned       count_acc;
  int                fails;
  int                reported;

  // Floor of the square root, one result bit at a time from the top
  function automatic logic [ROOT_W-1:0] floor_sqrt(input logic [SQ_W-1:0] x);
    logic [ROOT_W-1:0] root;
    logic [ROOT_W-1:0] trial;
    logic [SQ_W-1:0]   trial_sq;
    root = '0;
    for (int i = ROOT_W - 1; i >= 0; i--) begin
      trial    = root | (ROOT_W'(1) << i);
      trial_sq = SQ_W'(trial) * SQ_W'(trial);
      if (trial_sq <= x) root = trial;
    end
    return root;
  endfunction

  task automatic flag(input string msg);
    fails++;
    if (reported < 10) begin
      reported++;
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  // Accumulate one accepted word; queue the moments when the vector closes
  task automatic take_sample(input logic [DATA_W-1:0] smp,
                             input logic [DATA_W-1:0] rmean);
    longint            s;
    longint            r;
    longint            d;
    logic [SQ_W-1:0]   mag;
    logic [SQ_W-1:0]   sq;
    logic [SQ_W:0]     wide;
    int unsigned       eff;
    longint            quot;
    logic [SQ_W-1:0]   msd;
    logic [ROOT_W-1:0] root;
    moments_t          m;
    s    = longint'(signed'(smp));
    r    = longint'(signed'(rmean));
    d    = s - r;
    mag  = (d < 0) ? SQ_W'(-d) : SQ_W'(d);
    sq   = (mag > 64'hFFFF_FFFF) ? '1 : mag * mag;
    // saturate the running square sum
    wide   = {1'b0, sq_acc} + {1'b0, sq};
    sq_acc = wide[SQ_W] ? '1 : wide[SQ_W-1:0];
    sum_acc += s;
    count_acc++;
    // zero acts as one, anything above the maximum as the maximum
    if (length_reg == '0)          eff = 1;
    else if (length_reg > MAX_LEN) eff = MAX_LEN;
    else                           eff = length_reg;
    if (count_acc >= eff) begin
      quot   = sum_acc / longint'(eff);
      msd    = sq_acc / SQ_W'(eff);
      root   = floor_sqrt(msd);
      m.mean = quot[DATA_W-1:0];
      m.std_dev = (root > ROOT_W'(32'h7FFF_FFFF)) ? {STD_W{1'b1}} : root[STD_W-1:0];
      moments_q = {moments_q, m};
      sum_acc   = 0;
      sq_acc    = '0;
      count_acc = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    moments_t exp_m;
    if (!rst_ni) begin
      length_reg   = LEN_W'(1);
      sum_acc      = 0;
      sq_acc       = '0;
      count_acc    = 0;
      fails        = 0;
      reported     = 0;
      moments_q.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // compare a delivered result word with the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        if (moments_q.size() == 0) begin
          flag($sformatf("unexpected result word %h", m_axis_tdata));
        end else begin
          exp_m = moments_q.pop_front();
          if (m_axis_tdata[31:0] !== exp_m.mean || m_axis_tdata[62:32] !== exp_m.std_dev ||
              m_axis_tdata[63] !== 1'b0) begin
            flag($sformatf("result mismatch: mean exp %h got %h, std exp %h got %h, pad %b",
                           exp_m.mean, m_axis_tdata[31:0], exp_m.std_dev,
                           m_axis_tdata[62:32], m_axis_tdata[63]));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) take_sample(s_axis_tdata[31:0], s_axis_tdata[63:32]);
      if (cfg_wr_en_i) length_reg = cfg_wr_data_i;
      pending_o    <= moments_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the vector mean and standard deviation block.
// A directed pass covers field extremes, zero length, the saturating square
// sum and a length change in a vector; random phases follow with oversize
// lengths, bursty input, a patterned receiver and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import vmsd_pkg::*;

  localparam int     TOTAL_ITEMS   = 1850;
  localparam int     SETTLE_CYCLES = 128;
  localparam int     HOLD_CYCLES   = 3000;
  localparam longint TIMEOUT_NS    = 8_000_000;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_wr_en_i   = 1'b0;
  logic [LEN_W-1:0]  cfg_wr_data_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [63:0]       m_axis_tdata;
  int                fail_count;
  int                pending;
  logic              hold_req      = 1'b0;
  int                items_sent    = 0;
  int                burst_left    = 0;

  always #2 clk_i = ~clk_i;

  vector_mean_and_std_deviation #(
    .MAX_LENGTH   (256),
    .SAMPLE_WIDTH (32)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  vmsd_checker #(
    .MAX_LEN (256)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Offer one word, hold it until accepted, then pace the burst
  task automatic send_word(input logic [DATA_W-1:0] smp, input logic [DATA_W-1:0] rmean);
    int gap;
    s_axis_tdata  <= {rmean, smp};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 10);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      // mostly short bursts, now and then a long stretch without gaps
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
    end
  endtask

  // Drop valid, wait for every expected result, then let the pipe go quiet
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    drain_results();
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= len;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] extreme_word();
    case ($urandom_range(0, 4))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Small Q16.16 value in about -8.0 .. +8.0
  function automatic logic [DATA_W-1:0] small_word();
    return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
  endfunction

  // Build one word in the given style around the vector's reference mean
  task automatic send_styled(input int style, input logic [DATA_W-1:0] vec_mean);
    logic [DATA_W-1:0] smp;
    logic [DATA_W-1:0] rmean;
    rmean = vec_mean;
    case (style)
      0:       smp = $urandom();
      1:       smp = vec_mean + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      2:       begin
        smp   = extreme_word();
        rmean = extreme_word();
      end
      default: smp = vec_mean + small_word();
    endcase
    // occasional stray reference mean inside a vector
    if ($urandom_range(0, 7) == 0) rmean = $urandom();
    send_word(smp, rmean);
  endtask

  // Receiver: ready pattern changes mode after each random span
  initial begin : receiver
    int mode;
    int span;
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk_i);
        // one long hold-off while the sender keeps offering
        if (hold_req && !hold_done) begin
          m_axis_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
          hold_done = 1'b1;
        end
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int                r;
    int                phase;
    int                len;
    int                eff;
    int                nvec;
    int                extra;
    int                style;
    logic [DATA_W-1:0] vec_mean;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Length one after reset: zero, both signed extremes, all ones
    send_word(32'h0000_0000, 32'h0000_0000);
    send_word(32'h7FFF_FFFF, 32'h8000_0000);
    send_word(32'h8000_0000, 32'h7FFF_FFFF);
    send_word(32'hFFFF_FFFF, 32'h0000_0000);
    send_word(32'h8000_0000, 32'h8000_0000);

    // Zero length acts as one
    write_length('0);
    send_word(32'h0001_8000, 32'h0001_0000);

    // Negative sums truncate toward zero; then the largest mean
    write_length(LEN_W'(3));
    send_word(32'hFFFF_FFFF, 32'h0000_0000);
    send_word(32'hFFFF_FFFF, 32'h0000_0000);
    send_word(32'h0000_0000, 32'h0000_0000);
    repeat (3) send_word(32'h7FFF_FFFF, 32'h0000_0000);

    // Two maximal deviations saturate the square sum and the root
    write_length(LEN_W'(2));
    send_word(32'h7FFF_FFFF, 32'h8000_0000);
    send_word(32'h8000_0000, 32'h7FFF_FFFF);

    // Shrink the length below the count inside a vector
    write_length(LEN_W'(8));
    repeat (3) send_word(small_word(), small_word());
    write_length(LEN_W'(2));
    send_word(small_word(), small_word());

    // Random phases, each with its own length
    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      r = $urandom_range(0, 99);
      if (phase == 0)      len = 1;
      else if (phase == 3) len = 256;
      else if (phase == 7) len = 511;
      else if (r < 55)     len = $urandom_range(1, 4);
      else if (r < 75)     len = $urandom_range(5, 16);
      else if (r < 85)     len = $urandom_range(17, 64);
      else if (r < 92)     len = 0;
      else if (r < 94)     len = $urandom_range(257, 510);
      else                 len = 1;
      write_length(LEN_W'(len));
      if (phase == 0) hold_req <= 1'b1;

      if (len == 0)        eff = 1;
      else if (len > 256)  eff = 256;
      else                 eff = len;
      if (phase == 0)      nvec = 40;
      else if (eff <= 4)   nvec = $urandom_range(5, 40);
      else if (eff <= 16)  nvec = $urandom_range(2, 8);
      else if (eff <= 64)  nvec = $urandom_range(1, 3);
      else                 nvec = 1;
      // sometimes leave a partial vector for the next length to pick up
      extra = ($urandom_range(0, 3) == 0) ? $urandom_range(0, eff - 1) : 0;

      for (int v = 0; v < nvec; v++) begin
        style    = $urandom_range(0, 3);
        vec_mean = (style == 3) ? small_word() : $urandom();
        for (int k = 0; k < eff; k++) send_styled(style, vec_mean);
      end
      style    = $urandom_range(0, 3);
      vec_mean = $urandom();
      for (int k = 0; k < extra; k++) send_styled(style, vec_mean);
      phase++;
    end

    drain_results();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
